### hw/rtl/ibfs_pkg.sv
// shared types, constants and code rom for the ir beacon frame serialiser
`timescale 1ns / 1ps

package ibfs_pkg;

    localparam int unsigned APB_AW       = 3;
    localparam int unsigned APB_DW       = 32;
    localparam int unsigned TIMEOUT_W    = 16;
    localparam int unsigned SYMBOL_W     = 6;
    localparam int unsigned CODE_W       = 14;
    localparam int unsigned PHASE_W      = 2;
    localparam int unsigned SLOT_W       = 5;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;
    localparam logic [PHASE_W-1:0]   LAST_PHASE    = 2'd2;
    localparam logic [SLOT_W-1:0]    LAST_SLOT     = 5'd19;
    localparam logic [SLOT_W-1:0]    CODE_W_SHIFT  = 5'd14;

    // register index carried in paddr[2]
    localparam logic REG_TIMEOUT_IDX = 1'b0;

    typedef enum logic
    {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } ibfs_cmd_t;

    typedef struct packed
    {
        logic valid;
        logic led;
    } ibfs_result_t;

    // symbols beyond the last codeword read as zero
    localparam logic [CODE_W-1:0] CODE_ROM [64] = '{
        14'h0000, 14'h0197, 14'h02B9, 14'h032E, 14'h04E5,
        14'h0572, 14'h065C, 14'h07CB, 14'h0874, 14'h09E3,
        14'h0ACD, 14'h0B5A, 14'h0C91, 14'h0D06, 14'h0E28,
        14'h0FBF, 14'h10E8, 14'h117F, 14'h1251, 14'h13C6,
        14'h140D, 14'h159A, 14'h16B4, 14'h1723, 14'h189C,
        14'h190B, 14'h1A25, 14'h1BB2, 14'h1C79, 14'h1DEE,
        14'h1EC0, 14'h1F57, 14'h2047, 14'h21D0, 14'h22FE,
        14'h2369, 14'h24A2, 14'h2535, 14'h261B, 14'h278C,
        14'h2833, 14'h29A4, 14'h2A8A, 14'h2B1D, 14'h2CD6,
        14'h2D41, 14'h2E6F, 14'h2FF8, 14'h30AF, 14'h3138,
        14'h3216, 14'h3381, 14'h344A, 14'h35DD, 14'h36F3,
        14'h3764, 14'h38DB, 14'h394C, 14'h3A62, 14'h3BF5,
        14'h0000, 14'h0000, 14'h0000, 14'h0000
    };

endpackage

### hw/rtl/ibfs_in_if.sv
// input channel: command and symbol with valid/ready
`timescale 1ns / 1ps

interface ibfs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [ibfs_pkg::SYMBOL_W-1:0] symbol;

    modport source (output valid, output cmd, output symbol, input ready);
    modport sink   (input valid, input cmd, input symbol, output ready);
endinterface

### hw/rtl/ibfs_out_if.sv
// output channel: led drive with valid/ready
`timescale 1ns / 1ps

interface ibfs_out_if;
    logic valid;
    logic ready;
    logic led;

    modport source (output valid, output led, input ready);
    modport sink   (input valid, input led, output ready);
endinterface

### hw/rtl/ibfs_cfg.sv
// apb register block holding the command timeout
`timescale 1ns / 1ps

module ibfs_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ibfs_pkg::APB_AW-1:0]      paddr,
    input  logic [ibfs_pkg::APB_DW-1:0]      pwdata,
    output logic [ibfs_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output logic [ibfs_pkg::TIMEOUT_W-1:0]   timeout
);
    import ibfs_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIMEOUT_W-1:0] timeout_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT_IDX);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (wr_en)
        begin
            timeout_next = pwdata[TIMEOUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // low address bits ignored, words beyond the timeout read as zero
    assign prdata  = (paddr[2] == REG_TIMEOUT_IDX) ?
                     {{(APB_DW-TIMEOUT_W){1'b0}}, timeout_reg} : '0;
    assign timeout = timeout_reg;

endmodule

### hw/rtl/ibfs_engine.sv
// frame state: countdown, phase and slot counters, codeword latch and led select
`timescale 1ns / 1ps

module ibfs_engine
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             cmd,
    input  logic [ibfs_pkg::SYMBOL_W-1:0]    symbol,
    input  logic [ibfs_pkg::TIMEOUT_W-1:0]   timeout,
    output ibfs_pkg::ibfs_result_t           result
);
    import ibfs_pkg::*;

    logic [TIMEOUT_W-1:0] countdown_reg;
    logic [TIMEOUT_W-1:0] countdown_next;
    logic [SYMBOL_W-1:0]  symbol_reg;
    logic [SYMBOL_W-1:0]  symbol_next;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;
    logic [SLOT_W-1:0]    shift;
    logic                 data_bit;
    logic                 led;

    always_comb
    begin
        countdown_next = countdown_reg;
        symbol_next    = symbol_reg;
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        code_next      = code_reg;
        if (accept)
        begin
            if (cmd == CMD_SET)
            begin
                symbol_next    = symbol;
                countdown_next = timeout;
            end
            else if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - 1'b1;
                if (phase_reg < LAST_PHASE)
                begin
                    phase_next = phase_reg + 1'b1;
                end
                else
                begin
                    phase_next = '0;
                    if (slot_reg < LAST_SLOT)
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                    else
                    begin
                        slot_next = '0;
                        code_next = CODE_ROM[symbol_reg];
                    end
                end
            end
        end
    end

    // data slots send codeword bit 19 - slot, bits above the codeword are zero
    assign shift    = LAST_SLOT - slot_next;
    assign data_bit = (shift < CODE_W_SHIFT) ? code_next[shift[3:0]] : 1'b0;

    always_comb
    begin
        if (countdown_reg == '0)
        begin
            led = 1'b0;
        end
        else if ((slot_next == '0) && (phase_next <= 2'd1))
        begin
            led = 1'b1;
        end
        else if (slot_next <= 5'd1)
        begin
            led = 1'b0;
        end
        else if (phase_next == '0)
        begin
            led = 1'b1;
        end
        else
        begin
            led = data_bit;
        end
    end

    assign result.valid = accept && (cmd == CMD_TICK);
    assign result.led   = led;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= '0;
            symbol_reg    <= '0;
            phase_reg     <= LAST_PHASE;
            slot_reg      <= LAST_SLOT;
            code_reg      <= '0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            symbol_reg    <= symbol_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            code_reg      <= code_next;
        end
    end

endmodule

### hw/rtl/ibfs_out_stage.sv
// result register between the engine and the output channel
`timescale 1ns / 1ps

module ibfs_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ibfs_pkg::ibfs_result_t result,
    output logic                   in_ready,
    ibfs_out_if.source             out_ch
);
    import ibfs_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic led_reg;
    logic led_next;

    // accept while empty or while the held result leaves this cycle
    assign in_ready = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        led_next   = led_reg;
        if (result.valid)
        begin
            valid_next = 1'b1;
            led_next   = result.led;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        led_reg <= led_next;
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.led   = led_reg;

endmodule

### hw/rtl/ir_beacon_frame_serializer.sv
// top level of the ir beacon frame serialiser
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      cmd (1), symbol (6)
//  out_ch    out  valid/ready      led (1)
//  apb       in   psel/penable     command_timeout at byte 0
//
// one item per cycle while the result register is not stalled; a tick gives its led
// in the cycle after the transfer from the result register, a set command gives no result
// reset puts counters at phase 2, slot 19, countdown 0 and timeout 60
// a stalled result holds the register and input ready falls until it leaves
`timescale 1ns / 1ps

module ir_beacon_frame_serializer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ibfs_pkg::APB_AW-1:0]    paddr,
    input  logic [ibfs_pkg::APB_DW-1:0]    pwdata,
    output logic [ibfs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    ibfs_in_if.sink                        in_ch,
    ibfs_out_if.source                     out_ch
);
    import ibfs_pkg::*;

    logic [TIMEOUT_W-1:0] timeout;
    logic                 ready;
    logic                 accept;
    ibfs_result_t         result;

    assign in_ch.ready = ready;
    assign accept      = in_ch.valid && ready;

    ibfs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timeout (timeout)
    );

    ibfs_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (in_ch.cmd),
        .symbol  (in_ch.symbol),
        .timeout (timeout),
        .result  (result)
    );

    ibfs_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .in_ready (ready),
        .out_ch   (out_ch)
    );

endmodule

### hw/rtl/ibfs_checker.sv
// port-level checks for the ir beacon frame serialiser, bound to the top level
`timescale 1ns / 1ps

module ibfs_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_cmd,
    input logic out_valid,
    input logic out_ready,
    input logic out_led
);
    import ibfs_pkg::*;

    // a held result stays put until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_led))
        else $error("result changed while stalled");

    // a tick transfer always leaves a result behind
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_TICK) |=> out_valid)
        else $error("tick gave no result");

    // a set command never produces a result
    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_SET) |=> !out_valid)
        else $error("set command produced a result");

    // input side only stalls behind a stalled result
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow result register");

endmodule

bind ir_beacon_frame_serializer ibfs_checker u_ibfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_led   (out_ch.led)
);

### tb/tb.sv
// self-checking testbench for the ir beacon frame serialiser
`timescale 1ns / 1ps

module tb;

    import ibfs_pkg::*;

    localparam int PHASE_TOP   = 2;
    localparam int SLOT_TOP    = 19;
    localparam int ROM_ENTRIES = 60;
    localparam int PHASE_ITEMS = 46;
    localparam int SETTLE      = 4;

    // codewords per symbol, symbols at or past ROM_ENTRIES give zero
    localparam logic [CODE_W-1:0] BEACON_CODES [ROM_ENTRIES] = '{
        14'h0000, 14'h0197, 14'h02B9, 14'h032E, 14'h04E5,
        14'h0572, 14'h065C, 14'h07CB, 14'h0874, 14'h09E3,
        14'h0ACD, 14'h0B5A, 14'h0C91, 14'h0D06, 14'h0E28,
        14'h0FBF, 14'h10E8, 14'h117F, 14'h1251, 14'h13C6,
        14'h140D, 14'h159A, 14'h16B4, 14'h1723, 14'h189C,
        14'h190B, 14'h1A25, 14'h1BB2, 14'h1C79, 14'h1DEE,
        14'h1EC0, 14'h1F57, 14'h2047, 14'h21D0, 14'h22FE,
        14'h2369, 14'h24A2, 14'h2535, 14'h261B, 14'h278C,
        14'h2833, 14'h29A4, 14'h2A8A, 14'h2B1D, 14'h2CD6,
        14'h2D41, 14'h2E6F, 14'h2FF8, 14'h30AF, 14'h3138,
        14'h3216, 14'h3381, 14'h344A, 14'h35DD, 14'h36F3,
        14'h3764, 14'h38DB, 14'h394C, 14'h3A62, 14'h3BF5
    };

    typedef struct packed
    {
        ibfs_cmd_t             cmd;
        logic [SYMBOL_W-1:0]   symbol;
    } beacon_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    ibfs_in_if  in_ch ();
    ibfs_out_if out_ch ();

    ir_beacon_frame_serializer dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    beacon_item_t items_to_send [$];
    logic         expected_leds [$];
    int           mismatches = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    // beacon state as predicted
    logic [TIMEOUT_W-1:0] timeout_reg = TIMEOUT_RESET;
    logic [TIMEOUT_W-1:0] countdown   = '0;
    logic [SYMBOL_W-1:0]  stored_sym  = '0;
    logic [PHASE_W-1:0]   phase       = 2'd2;
    logic [SLOT_W-1:0]    slot        = 5'd19;
    logic [CODE_W-1:0]    code        = '0;

    function automatic void beacon_step(ibfs_cmd_t cmd, logic [SYMBOL_W-1:0] sym);
        logic [17:0] wide;
        logic        led;
        if (cmd == CMD_SET)
        begin
            stored_sym = sym;
            countdown  = timeout_reg;
            return;
        end
        if (countdown == 0)
        begin
            expected_leds.push_back(1'b0);
            return;
        end
        countdown = countdown - 1'b1;
        if (phase < PHASE_TOP)
            phase = phase + 1'b1;
        else
        begin
            phase = '0;
            if (slot < SLOT_TOP)
                slot = slot + 1'b1;
            else
            begin
                slot = '0;
                code = (stored_sym < ROM_ENTRIES) ? BEACON_CODES[stored_sym] : '0;
            end
        end
        wide = {4'b0000, code};
        if (slot == 0 && phase <= 1)
            led = 1'b1;
        else if (slot <= 1)
            led = 1'b0;
        else if (phase == 0)
            led = 1'b1;
        else
            led = wide[SLOT_TOP - int'(slot)];
        expected_leds.push_back(led);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void queue_item(ibfs_cmd_t cmd, logic [SYMBOL_W-1:0] sym);
        beacon_item_t it;
        it.cmd    = cmd;
        it.symbol = sym;
        items_to_send.push_back(it);
    endfunction

    function automatic void queue_ticks(int count);
        for (int i = 0; i < count; i++)
            queue_item(CMD_TICK, SYMBOL_W'($urandom_range(63)));
    endfunction

    // mostly a set followed by 20 to 90 ticks, with stray sets and noise mixed in
    function automatic void queue_traffic(int count);
        int queued;
        int roll;
        int n;
        queued = 0;
        while (queued < count)
        begin
            roll = $urandom_range(99);
            if (roll < 75)
            begin
                if ($urandom_range(3) == 0)
                    queue_item(CMD_SET, SYMBOL_W'($urandom_range(63, 56)));
                else
                    queue_item(CMD_SET, SYMBOL_W'($urandom_range(63)));
                n = $urandom_range(90, 20);
                queue_ticks(n);
                queued += n + 1;
            end
            else if (roll < 90)
            begin
                queue_item(CMD_SET, SYMBOL_W'($urandom_range(63)));
                queued++;
            end
            else
            begin
                n = $urandom_range(5, 1);
                for (int i = 0; i < n; i++)
                    queue_item(ibfs_cmd_t'($urandom_range(1)), SYMBOL_W'($urandom_range(63)));
                queued += n;
            end
        end
    endfunction

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TIMEOUT_IDX, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        timeout_reg = value;
    endtask

    // sampled on the falling edge so the driver has settled
    task automatic wait_drained();
        @(negedge clk);
        while (items_to_send.size() != 0 || in_ch.valid || expected_leds.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(input logic [TIMEOUT_W-1:0] timeout, input int idle_pct,
                             input int stall_pct);
        write_timeout(timeout);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_traffic(PHASE_ITEMS);
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // input side: a new item goes out once the previous transfer has happened
    always @(posedge clk)
    begin : drive_items
        beacon_item_t it;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                beacon_step(ibfs_cmd_t'(in_ch.cmd), in_ch.symbol);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    it = items_to_send.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.cmd    <= it.cmd;
                    in_ch.symbol <= it.symbol;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_leds
        logic want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_leds.size() == 0)
                report_mismatch($sformatf("unexpected led transfer, led=%b", out_ch.led));
            else
            begin
                want = expected_leds.pop_front();
                if (out_ch.led !== want)
                    report_mismatch($sformatf("led got %b want %b", out_ch.led, want));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_TICK;
        in_ch.symbol = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle ticks, last rom entry, reload mid-frame, symbol past the rom
        @(negedge clk);
        queue_item(CMD_TICK, 6'd63);
        queue_item(CMD_TICK, 6'd0);
        queue_item(CMD_SET, 6'd59);
        queue_ticks(16);
        queue_item(CMD_SET, 6'd60);
        queue_ticks(3);
        queue_item(CMD_SET, 6'd0);
        queue_item(CMD_TICK, 6'd63);
        wait_drained();

        run_phase(16'd0, 54, 0);
        run_phase(16'hFFFF, 0, 54);
        run_phase(16'd60, 23, 23);
        run_phase(16'd1, 0, 0);
        run_phase(TIMEOUT_W'($urandom_range(200, 2)), 54, 0);
        run_phase(16'd60, 0, 54);
        run_phase(16'd3, 23, 23);
        run_phase(16'd60, 0, 0);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### ir_beacon_frame_serializer.f
hw/rtl/ibfs_pkg.sv
hw/rtl/ibfs_in_if.sv
hw/rtl/ibfs_out_if.sv
hw/rtl/ibfs_cfg.sv
hw/rtl/ibfs_engine.sv
hw/rtl/ibfs_out_stage.sv
hw/rtl/ir_beacon_frame_serializer.sv
hw/rtl/ibfs_checker.sv
tb/tb.sv
